### rtl/tse_pkg.sv
`default_nettype none

package tse_pkg;

   localparam int VERTEX_W = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 8;

   typedef enum logic {
      KIND_ADD_EDGE = 1'b0,
      KIND_RUN      = 1'b1
   } kind_type;

endpackage

`default_nettype wire

### rtl/tse_ram.sv
`default_nettype none

module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/topological_sort_engine_unit.sv
// An add-edge transfer is limited by the degree memory read.
// A run walks n vertices, E stored edges and P emitted vertices through the
// single read port of each working memory, and it waits while a stalled
// result holds the output register.
// One item is in flight at a time; results leave through an output register.
// Reset is synchronous and active high; it clears the degree valid bits, the
// dropped-edge flag and the vertex count (to 1); edge storage is not cleared.
`default_nettype none

module topological_sort_engine_unit #(
   parameter int MAX_VERTICES  = 64,
   parameter int MAX_OUT_EDGES = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_tvalid,
   output logic                                 csr_tready,
   input  wire logic [tse_pkg::CSR_DATA_W-1:0]  csr_tdata,  // vertex_count[6:0]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tse_pkg::REQ_DATA_W-1:0]  req_tdata,  // from_vertex[6:0], to_vertex[13:7]
   input  wire logic [0:0]                      req_tuser,  // kind[0]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [tse_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // vertex[6:0], complete[7], overflow[8]
   output logic                                 rsp_tlast
);

   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int VCW  = $clog2(MAX_VERTICES + 1);
   localparam int CW   = (VCW > tse_pkg::VERTEX_W) ? VCW : tse_pkg::VERTEX_W;
   localparam int KW   = $clog2(MAX_OUT_EDGES + 1);
   localparam int AW   = $clog2(MAX_VERTICES * MAX_OUT_EDGES);
   localparam int IDW  = $clog2(MAX_VERTICES * MAX_OUT_EDGES + 1);
   localparam int VTW  = tse_pkg::VERTEX_W;

   typedef enum logic [4:0] {
      S_IDLE, S_ADD, S_CLR,
      S_CNT_RD, S_CNT_D, S_CNT_ADJ, S_CNT_T, S_CNT_INC,
      S_SEED_RD, S_SEED_CHK,
      S_POP_RD, S_POP_X, S_POP_D, S_EMIT, S_POP_ADJ, S_POP_T, S_POP_DEC,
      S_FIN
   } state_type;

   state_type        state_ff;
   logic [VTW-1:0]   vcount_ff;
   logic             dropped_ff;
   logic [MAX_VERTICES-1:0] odeg_vld_ff;
   logic [VCW-1:0]   s_ff;
   logic [KW-1:0]    k_ff;
   logic [KW-1:0]    d_ff;
   logic [VW-1:0]    f_ff;
   logic [VTW-1:0]   t_ff;
   logic [VW-1:0]    x_ff;
   logic [VW-1:0]    pend_ff;
   logic [VCW-1:0]   head_ff;
   logic [VCW-1:0]   tail_ff;
   logic [VCW-1:0]   count_ff;
   logic             rsp_valid_ff;
   logic [VTW-1:0]   rsp_vertex_ff;
   logic             rsp_last_ff;
   logic             rsp_complete_ff;
   logic             rsp_overflow_ff;

   logic [CW-1:0]    n_act;
   logic [CW-1:0]    req_from;
   logic [CW-1:0]    req_to;
   logic             req_fire;
   logic             req_ok;
   logic             slot_free;
   logic             rsp_load;
   logic [CW-1:0]    t_ext;
   logic             t_ok;
   logic [VW-1:0]    t_idx;
   logic [KW-1:0]    odeg_eff;
   logic [CW-1:0]    pend_num;
   logic [VCW-1:0]   s_next;
   logic [KW-1:0]    k_next;

   logic            odeg_we;
   logic [VW-1:0]   odeg_wa;
   logic [KW-1:0]   odeg_wd;
   logic [VW-1:0]   odeg_ra;
   logic [KW-1:0]   odeg_q;
   logic            adj_we;
   logic [AW-1:0]   adj_wa;
   logic [VTW-1:0]  adj_wd;
   logic [AW-1:0]   adj_ra;
   logic [VTW-1:0]  adj_q;
   logic            indeg_we;
   logic [VW-1:0]   indeg_wa;
   logic [IDW-1:0]  indeg_wd;
   logic [VW-1:0]   indeg_ra;
   logic [IDW-1:0]  indeg_q;
   logic            rq_we;
   logic [VW-1:0]   rq_wa;
   logic [VW-1:0]   rq_wd;
   logic [VW-1:0]   rq_ra;
   logic [VW-1:0]   rq_q;

   always_comb begin
      if (vcount_ff == '0) begin
         n_act = CW'(1);
      end else if (CW'(vcount_ff) > CW'(MAX_VERTICES)) begin
         n_act = CW'(MAX_VERTICES);
      end else begin
         n_act = CW'(vcount_ff);
      end
   end

   assign req_from  = CW'(req_tdata[VTW-1:0]);
   assign req_to    = CW'(req_tdata[2*VTW-1:VTW]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign req_ok    = (req_from != '0) && (req_from <= n_act) &&
                      (req_to != '0) && (req_to <= n_act);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = ((state_ff == S_EMIT) && (count_ff != '0) && slot_free) ||
                      ((state_ff == S_FIN) && slot_free);
   assign t_ext     = CW'(adj_q);
   assign t_ok      = (t_ext != '0) && (t_ext <= n_act);
   assign t_idx     = VW'(CW'(t_ff) - CW'(1));
   assign pend_num  = CW'(pend_ff) + CW'(1);
   assign s_next    = s_ff + VCW'(1);
   assign k_next    = k_ff + KW'(1);

   always_comb begin
      if (state_ff == S_ADD) begin
         odeg_eff = odeg_vld_ff[f_ff] ? odeg_q : '0;
      end else begin
         odeg_eff = odeg_vld_ff[x_ff] ? odeg_q : '0;
      end
   end

   always_comb begin
      odeg_we  = 1'b0;
      odeg_wa  = f_ff;
      odeg_wd  = odeg_eff + KW'(1);
      odeg_ra  = VW'(req_from - CW'(1));
      adj_we   = 1'b0;
      adj_wa   = AW'(AW'(f_ff) * AW'(MAX_OUT_EDGES) + AW'(odeg_eff));
      adj_wd   = t_ff;
      adj_ra   = AW'(AW'(s_ff[VW-1:0]) * AW'(MAX_OUT_EDGES) + AW'(k_ff));
      indeg_we = 1'b0;
      indeg_wa = t_idx;
      indeg_wd = indeg_q + IDW'(1);
      indeg_ra = VW'(t_ext - CW'(1));
      rq_we    = 1'b0;
      rq_wa    = tail_ff[VW-1:0];
      rq_wd    = t_idx;
      rq_ra    = head_ff[VW-1:0];
      case (state_ff)
         S_ADD: begin
            if (odeg_eff < KW'(MAX_OUT_EDGES)) begin
               odeg_we = 1'b1;
               adj_we  = 1'b1;
            end
         end
         S_CLR: begin
            indeg_we = 1'b1;
            indeg_wa = s_ff[VW-1:0];
            indeg_wd = '0;
         end
         S_CNT_RD: begin
            odeg_ra = s_ff[VW-1:0];
         end
         S_CNT_INC: begin
            indeg_we = 1'b1;
         end
         S_SEED_RD: begin
            indeg_ra = s_ff[VW-1:0];
         end
         S_SEED_CHK: begin
            if (indeg_q == '0) begin
               rq_we = 1'b1;
               rq_wd = s_ff[VW-1:0];
            end
         end
         S_POP_X: begin
            odeg_ra = rq_q;
         end
         S_POP_ADJ: begin
            adj_ra = AW'(AW'(x_ff) * AW'(MAX_OUT_EDGES) + AW'(k_ff));
         end
         S_POP_DEC: begin
            if (indeg_q != '0) begin
               indeg_we = 1'b1;
               indeg_wd = indeg_q - IDW'(1);
               if (indeg_q == IDW'(1)) begin
                  rq_we = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= VTW'(1);
         dropped_ff   <= 1'b0;
         odeg_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_tvalid && csr_tready) begin
            vcount_ff <= csr_tdata[VTW-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser[0] == tse_pkg::KIND_RUN) begin
                     s_ff     <= '0;
                     head_ff  <= '0;
                     tail_ff  <= '0;
                     count_ff <= '0;
                     state_ff <= S_CLR;
                  end else if (req_ok) begin
                     f_ff     <= VW'(req_from - CW'(1));
                     t_ff     <= req_tdata[2*VTW-1:VTW];
                     state_ff <= S_ADD;
                  end
               end
            end
            S_ADD: begin
               if (odeg_eff < KW'(MAX_OUT_EDGES)) begin
                  odeg_vld_ff[f_ff] <= 1'b1;
               end else begin
                  dropped_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_CLR: begin
               if (CW'(s_next) == n_act) begin
                  s_ff     <= '0;
                  state_ff <= S_CNT_RD;
               end else begin
                  s_ff <= s_next;
               end
            end
            S_CNT_RD: begin
               state_ff <= S_CNT_D;
            end
            S_CNT_D: begin
               d_ff <= odeg_vld_ff[s_ff[VW-1:0]] ? odeg_q : '0;
               k_ff <= '0;
               if (!odeg_vld_ff[s_ff[VW-1:0]] || odeg_q == '0) begin
                  if (CW'(s_next) == n_act) begin
                     s_ff     <= '0;
                     state_ff <= S_SEED_RD;
                  end else begin
                     s_ff     <= s_next;
                     state_ff <= S_CNT_RD;
                  end
               end else begin
                  state_ff <= S_CNT_ADJ;
               end
            end
            S_CNT_ADJ: begin
               state_ff <= S_CNT_T;
            end
            S_CNT_T, S_CNT_INC: begin
               if (state_ff == S_CNT_T && t_ok) begin
                  t_ff     <= adj_q;
                  state_ff <= S_CNT_INC;
               end else if (k_next == d_ff) begin
                  if (CW'(s_next) == n_act) begin
                     s_ff     <= '0;
                     state_ff <= S_SEED_RD;
                  end else begin
                     s_ff     <= s_next;
                     state_ff <= S_CNT_RD;
                  end
               end else begin
                  k_ff     <= k_next;
                  state_ff <= S_CNT_ADJ;
               end
            end
            S_SEED_RD: begin
               state_ff <= S_SEED_CHK;
            end
            S_SEED_CHK: begin
               if (indeg_q == '0) begin
                  tail_ff <= tail_ff + VCW'(1);
               end
               if (CW'(s_next) == n_act) begin
                  state_ff <= S_POP_RD;
               end else begin
                  s_ff     <= s_next;
                  state_ff <= S_SEED_RD;
               end
            end
            S_POP_RD: begin
               if (head_ff == tail_ff) begin
                  state_ff <= S_FIN;
               end else begin
                  head_ff  <= head_ff + VCW'(1);
                  state_ff <= S_POP_X;
               end
            end
            S_POP_X: begin
               x_ff     <= rq_q;
               state_ff <= S_POP_D;
            end
            S_POP_D: begin
               d_ff     <= odeg_eff;
               k_ff     <= '0;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (count_ff == '0 || slot_free) begin
                  if (count_ff != '0) begin
                     rsp_vertex_ff   <= pend_num[VTW-1:0];
                     rsp_last_ff     <= 1'b0;
                     rsp_complete_ff <= 1'b0;
                     rsp_overflow_ff <= 1'b0;
                  end
                  pend_ff  <= x_ff;
                  count_ff <= count_ff + VCW'(1);
                  state_ff <= (d_ff == '0) ? S_POP_RD : S_POP_ADJ;
               end
            end
            S_POP_ADJ: begin
               state_ff <= S_POP_T;
            end
            S_POP_T, S_POP_DEC: begin
               if (state_ff == S_POP_DEC && indeg_q == IDW'(1)) begin
                  tail_ff <= tail_ff + VCW'(1);
               end
               if (state_ff == S_POP_T && t_ok) begin
                  t_ff     <= adj_q;
                  state_ff <= S_POP_DEC;
               end else if (k_next == d_ff) begin
                  state_ff <= S_POP_RD;
               end else begin
                  k_ff     <= k_next;
                  state_ff <= S_POP_ADJ;
               end
            end
            S_FIN: begin
               if (slot_free) begin
                  rsp_vertex_ff   <= (count_ff == '0) ? '0 : pend_num[VTW-1:0];
                  rsp_last_ff     <= 1'b1;
                  rsp_complete_ff <= (CW'(count_ff) == n_act);
                  rsp_overflow_ff <= dropped_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   tse_ram #(.WIDTH(KW), .DEPTH(MAX_VERTICES)) u_odeg (
      .clock(clock), .wr_en(odeg_we), .wr_addr(odeg_wa), .wr_data(odeg_wd),
      .rd_addr(odeg_ra), .rd_data(odeg_q)
   );

   tse_ram #(.WIDTH(VTW), .DEPTH(MAX_VERTICES * MAX_OUT_EDGES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_q)
   );

   tse_ram #(.WIDTH(IDW), .DEPTH(MAX_VERTICES)) u_indeg (
      .clock(clock), .wr_en(indeg_we), .wr_addr(indeg_wa), .wr_data(indeg_wd),
      .rd_addr(indeg_ra), .rd_data(indeg_q)
   );

   tse_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_rq (
      .clock(clock), .wr_en(rq_we), .wr_addr(rq_wa), .wr_data(rq_wd),
      .rd_addr(rq_ra), .rd_data(rq_q)
   );

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(tse_pkg::RSP_DATA_W - VTW - 2){1'b0}}, rsp_overflow_ff,
                        rsp_complete_ff, rsp_vertex_ff};

`ifndef ASSERT_OFF
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff || state_ff == S_IDLE || state_ff == S_ADD)
      else $error("ready queue head passed its tail");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[0] == tse_pkg::KIND_RUN |=> state_ff == S_CLR)
      else $error("run transfer did not start the clearing pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> CW'(count_ff) <= n_act)
      else $error("more vertices emitted than in use");

   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && slot_free |=> rsp_tvalid && rsp_tlast)
      else $error("final result not presented");
`endif

endmodule

`default_nettype wire
